// ----- src/sm3bc_pkg.sv -----
package sm3bc_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned NUM_ROUNDS  = 64;
    localparam int unsigned POS_W       = $clog2(BLOCK_WORDS);
    localparam int unsigned ROUND_W     = $clog2(NUM_ROUNDS);

    localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(BLOCK_WORDS - 1);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

    // Rounds below this index use the XOR boolean functions and T0
    localparam logic [ROUND_W-1:0] FIRST_MAJ_ROUND = ROUND_W'(16);

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam t_word T_LOW  = 32'h79CC4519;
    localparam t_word T_HIGH = 32'h7A879D8A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic               load_word;
        logic               reload_iv;
        logic               init_round;
        logic               round_en;
        logic [ROUND_W-1:0] round_idx;
        logic               finalize;
    } t_cmd;

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [2*WORD_W-1:0] d;
        d = {x, x} << n;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ----- src/sm3bc_ctrl.sv -----
module sm3bc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  i_start_message,
    output logic                  busy,
    output logic                  o_done,
    output sm3bc_pkg::t_cmd       o_cmd
);

    sm3bc_pkg::t_state                   r_state, n_state;
    logic [sm3bc_pkg::POS_W-1:0]         r_pos, n_pos;
    logic [sm3bc_pkg::ROUND_W-1:0]       r_round, n_round;
    logic                                r_done, n_done;

    logic                                accept;
    logic [sm3bc_pkg::POS_W-1:0]         eff_pos;
    logic                                last_word;

    assign busy    = (r_state != sm3bc_pkg::ST_IDLE);
    assign o_done  = r_done;
    assign accept  = start & ~busy;
    // a start flag restarts the block at slot zero
    assign eff_pos   = i_start_message ? '0 : r_pos;
    assign last_word = (eff_pos == sm3bc_pkg::LAST_POS);

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sm3bc_pkg::ST_IDLE;
            r_pos   <= '0;
            r_round <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_round <= n_round;
            r_done  <= n_done;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_round = r_round;
        n_done  = 1'b0;
        o_cmd   = '0;
        o_cmd.round_idx = r_round;
        case (r_state)
            sm3bc_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_word = 1'b1;
                    o_cmd.reload_iv = i_start_message;
                    if (last_word) begin
                        o_cmd.init_round = 1'b1;
                        n_pos   = '0;
                        n_round = '0;
                        n_state = sm3bc_pkg::ST_ROUND;
                    end else begin
                        n_pos = eff_pos + 1'b1;
                    end
                end
            end
            sm3bc_pkg::ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 1'b1;
                if (r_round == sm3bc_pkg::LAST_ROUND) begin
                    n_state = sm3bc_pkg::ST_FINAL;
                end
            end
            sm3bc_pkg::ST_FINAL: begin
                o_cmd.finalize = 1'b1;
                n_done  = 1'b1;
                n_state = sm3bc_pkg::ST_IDLE;
            end
            default: begin
                n_state = sm3bc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/sm3bc_datapath.sv -----
module sm3bc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sm3bc_pkg::t_cmd       i_cmd,
    input  logic [31:0]           i_msg_word,
    output logic [63:0]           o_digest_w01,
    output logic [63:0]           o_digest_w23,
    output logic [63:0]           o_digest_w45,
    output logic [63:0]           o_digest_w67
);

    // chaining value and working variables a..h
    sm3bc_pkg::t_word r_cv [8];
    sm3bc_pkg::t_word r_v  [8];
    // message schedule window, r_w[0] holds W[j]
    sm3bc_pkg::t_word r_w  [sm3bc_pkg::BLOCK_WORDS];

    sm3bc_pkg::t_word w_new, w_in, tj, t_rot, a12, ss1, ss2, ffv, ggv, tt1, tt2;
    logic             early;

    // schedule expansion: next word W[j+16]
    assign w_new = sm3bc_pkg::perm1(r_w[0] ^ r_w[7] ^ sm3bc_pkg::rotl(r_w[13], 5'd15))
                   ^ sm3bc_pkg::rotl(r_w[3], 5'd7) ^ r_w[10];
    assign w_in  = i_cmd.load_word ? i_msg_word : w_new;

    // one compression round
    assign early = (i_cmd.round_idx < sm3bc_pkg::FIRST_MAJ_ROUND);
    assign tj    = early ? sm3bc_pkg::T_LOW : sm3bc_pkg::T_HIGH;
    assign t_rot = sm3bc_pkg::rotl(tj, i_cmd.round_idx[4:0]);
    assign a12   = sm3bc_pkg::rotl(r_v[0], 5'd12);
    assign ss1   = sm3bc_pkg::rotl(a12 + r_v[4] + t_rot, 5'd7);
    assign ss2   = ss1 ^ a12;
    assign ffv   = early ? (r_v[0] ^ r_v[1] ^ r_v[2])
                         : ((r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]));
    assign ggv   = early ? (r_v[4] ^ r_v[5] ^ r_v[6])
                         : ((r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]));
    assign tt1   = ffv + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
    assign tt2   = ggv + r_v[7] + ss1 + r_w[0];

    // schedule window shifts on each loaded word and each round
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word || i_cmd.round_en) begin
            for (int i = 0; i < sm3bc_pkg::BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sm3bc_pkg::BLOCK_WORDS-1] <= w_in;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_round) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_cv[i];
            end
        end else if (i_cmd.round_en) begin
            r_v[0] <= tt1;
            r_v[1] <= r_v[0];
            r_v[2] <= sm3bc_pkg::rotl(r_v[1], 5'd9);
            r_v[3] <= r_v[2];
            r_v[4] <= sm3bc_pkg::perm0(tt2);
            r_v[5] <= r_v[4];
            r_v[6] <= sm3bc_pkg::rotl(r_v[5], 5'd19);
            r_v[7] <= r_v[6];
        end
    end

    // chaining value: IV on reset or new message, feed-forward after a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reload_iv) begin
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= sm3bc_pkg::IV[i];
            end
        end else if (i_cmd.finalize) begin
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= r_cv[i] ^ r_v[i];
            end
        end
    end

    assign o_digest_w01 = {r_cv[0], r_cv[1]};
    assign o_digest_w23 = {r_cv[2], r_cv[3]};
    assign o_digest_w45 = {r_cv[4], r_cv[5]};
    assign o_digest_w67 = {r_cv[6], r_cv[7]};

endmodule

// ----- src/sm3_block_compression.sv -----
// SM3 block compression.
// Input items: a padded message, one big-endian 32-bit word per item on
// i_msg_word, taken at a clock edge with start high and busy low. Set
// i_start_message on the first word of a message: the chaining value
// reloads the IV and that word becomes word 0 of a new block, dropping any
// partly collected block.
// Words 0 to 14 of a block are taken one per cycle. The 16th word raises
// busy for 64 compression rounds, one per cycle in a single round unit
// with the message expansion running alongside, then the feed-forward
// XOR. The digest is on o_digest_w01..o_digest_w67 for one cycle, marked
// by o_done, in the cycle busy falls.
// The receiver cannot stall: o_done is a strobe. A new word may be given
// in the o_done cycle.
// Reset (synchronous, i_rst_n low) loads the IV, clears the word count
// and returns the controller to idle.
module sm3_block_compression (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_msg_word,
    input  logic        i_start_message,
    output logic        o_done,
    output logic [63:0] o_digest_w01,
    output logic [63:0] o_digest_w23,
    output logic [63:0] o_digest_w45,
    output logic [63:0] o_digest_w67
);

    sm3bc_pkg::t_cmd cmd;

    sm3bc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_start_message (i_start_message),
        .busy            (busy),
        .o_done          (o_done),
        .o_cmd           (cmd)
    );

    sm3bc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_msg_word   (i_msg_word),
        .o_digest_w01 (o_digest_w01),
        .o_digest_w23 (o_digest_w23),
        .o_digest_w45 (o_digest_w45),
        .o_digest_w67 (o_digest_w67)
    );

endmodule

// ----- src/sm3bc_checker.sv -----
module sm3bc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // digest strobe only while idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("digest strobe while busy");

    // strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("digest strobe longer than one cycle");

    // busy only follows an accepted item
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted item");

    // a block keeps the unit busy through all rounds
    a_busy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ##64 busy)
        else $error("block finished too early");

    // end of busy and the digest strobe coincide
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) == o_done)
        else $error("digest strobe not at end of block");

endmodule

bind sm3_block_compression sm3bc_checker u_sm3bc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned RESET_CYCLES = 8;
    localparam int unsigned RANDOM_WORDS = 1100;
    // slack run after the last expected digest is seen
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned IDLE_LIMIT   = 2000;

    typedef struct packed {
        sm3bc_pkg::t_word word;
        logic             first;
    } t_msg_item;

    typedef struct packed {
        logic [63:0] w01;
        logic [63:0] w23;
        logic [63:0] w45;
        logic [63:0] w67;
    } t_digest;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_msg_word;
    logic        i_start_message;
    logic        o_done;
    logic [63:0] o_digest_w01;
    logic [63:0] o_digest_w23;
    logic [63:0] o_digest_w45;
    logic [63:0] o_digest_w67;

    t_msg_item   word_queue[$];
    t_digest     expected_digests[$];

    // predicted block state
    sm3bc_pkg::t_word chain_v [8];
    sm3bc_pkg::t_word blk_v [16];
    logic [3:0]       wpos;

    int unsigned fail_count;
    int unsigned idle_cycles;
    logic        took_word;
    int unsigned burst_left;
    int unsigned gap_left;

    sm3_block_compression DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_msg_word      (i_msg_word),
        .i_start_message (i_start_message),
        .o_done          (o_done),
        .o_digest_w01    (o_digest_w01),
        .o_digest_w23    (o_digest_w23),
        .o_digest_w45    (o_digest_w45),
        .o_digest_w67    (o_digest_w67)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic sm3bc_pkg::t_word rol32(input sm3bc_pkg::t_word x,
                                               input int unsigned n);
        int unsigned k;
        k = n % 32;
        if (k == 0)
            return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic sm3bc_pkg::t_word mix0(input sm3bc_pkg::t_word x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic sm3bc_pkg::t_word mix1(input sm3bc_pkg::t_word x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    // one 64-round compression of blk_v into chain_v
    task automatic sm3_compress();
        sm3bc_pkg::t_word w [68];
        sm3bc_pkg::t_word a, b, c, d, e, f, g, h;
        sm3bc_pkg::t_word tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
        for (int j = 0; j < 16; j++)
            w[j] = blk_v[j];
        for (int j = 16; j < 68; j++)
            w[j] = mix1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15))
                   ^ rol32(w[j-13], 7) ^ w[j-6];
        a = chain_v[0]; b = chain_v[1]; c = chain_v[2]; d = chain_v[3];
        e = chain_v[4]; f = chain_v[5]; g = chain_v[6]; h = chain_v[7];
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? sm3bc_pkg::T_LOW : sm3bc_pkg::T_HIGH;
            a12 = rol32(a, 12);
            ss1 = rol32(a12 + e + rol32(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ffv = a ^ b ^ c;
                ggv = e ^ f ^ g;
            end else begin
                ffv = (a & b) | (a & c) | (b & c);
                ggv = (e & f) | (~e & g);
            end
            tt1 = ffv + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = ggv + h + ss1 + w[j];
            d = c;
            c = rol32(b, 9);
            b = a;
            a = tt1;
            h = g;
            g = rol32(f, 19);
            f = e;
            e = mix0(tt2);
        end
        chain_v[0] ^= a; chain_v[1] ^= b; chain_v[2] ^= c; chain_v[3] ^= d;
        chain_v[4] ^= e; chain_v[5] ^= f; chain_v[6] ^= g; chain_v[7] ^= h;
    endtask

    // take one accepted word; a completed block queues its digest
    task automatic sm3_absorb_word(input sm3bc_pkg::t_word word, input logic first);
        t_digest dg;
        if (first) begin
            chain_v = sm3bc_pkg::IV;
            wpos    = '0;
        end
        blk_v[wpos] = word;
        if (wpos != 4'd15) begin
            wpos = wpos + 4'd1;
        end else begin
            wpos = '0;
            sm3_compress();
            dg.w01 = {chain_v[0], chain_v[1]};
            dg.w23 = {chain_v[2], chain_v[3]};
            dg.w45 = {chain_v[4], chain_v[5]};
            dg.w67 = {chain_v[6], chain_v[7]};
            expected_digests.push_back(dg);
        end
    endtask

    function automatic sm3bc_pkg::t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return sm3bc_pkg::t_word'(1) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        if (r < 8)
            return $urandom_range(1, 5);
        return $urandom_range(6, 90);
    endfunction

    task automatic push_word(input sm3bc_pkg::t_word word, input logic first);
        t_msg_item it;
        it.word  = word;
        it.first = first;
        word_queue.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // driver: bursts of items with random gaps, inputs change at falling edge
    always @(negedge i_clk) begin : drive_words
        int unsigned b;
        int unsigned g;
        b = burst_left;
        g = gap_left;
        if (took_word) begin
            if (b <= 1) begin
                b = $urandom_range(1, 48);
                g = pick_gap();
            end else begin
                b--;
            end
        end
        if (g != 0) begin
            start <= 1'b0;
            g--;
        end else if (word_queue.size() != 0) begin
            start           <= 1'b1;
            i_msg_word      <= word_queue[0].word;
            i_start_message <= word_queue[0].first;
        end else begin
            start <= 1'b0;
        end
        burst_left = b;
        gap_left   = g;
    end

    // monitor, word acceptance and watchdog at the rising edge
    always @(posedge i_clk) begin : sample_edge
        logic    took;
        logic    progress;
        t_digest dg;
        took     = 1'b0;
        progress = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                progress = 1'b1;
                if (expected_digests.size() == 0) begin
                    $display("%0t: unexpected digest %h %h %h %h", $time,
                             o_digest_w01, o_digest_w23, o_digest_w45, o_digest_w67);
                    fail_count++;
                end else begin
                    dg = expected_digests.pop_front();
                    check_field("digest_w01", dg.w01, o_digest_w01);
                    check_field("digest_w23", dg.w23, o_digest_w23);
                    check_field("digest_w45", dg.w45, o_digest_w45);
                    check_field("digest_w67", dg.w67, o_digest_w67);
                end
            end
            if (start && !busy && word_queue.size() != 0) begin
                took     = 1'b1;
                progress = 1'b1;
                sm3_absorb_word(i_msg_word, i_start_message);
                void'(word_queue.pop_front());
            end
        end
        took_word <= took;
        if (progress)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        sm3bc_pkg::t_word first_blk [16];
        int unsigned      produced;
        int unsigned      kind;
        int unsigned      n;
        logic             first_kind;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_msg_word      = '0;
        i_start_message = 1'b0;
        took_word       = 1'b0;
        burst_left      = 16;
        gap_left        = 0;
        fail_count      = 0;
        idle_cycles     = 0;
        chain_v         = sm3bc_pkg::IV;
        wpos            = '0;

        // first block with no start flag runs from the reset IV
        first_blk = '{32'h00000000, 32'hFFFFFFFF, 32'h61626380, 32'h80000000,
                      32'h00000001, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF,
                      32'h00000000, 32'h7FFFFFFF, 32'hFFFFFFFE, 32'h01234567,
                      32'h89ABCDEF, 32'hFEDCBA98, 32'h00000000, 32'h00000018};
        for (int i = 0; i < 16; i++)
            push_word(first_blk[i], 1'b0);
        // partial block; the next message start restarts it mid-block
        push_word(32'hFFFFFFFF, 1'b1);
        push_word(32'h00000000, 1'b0);
        push_word(32'h12345678, 1'b0);

        // random part: mostly whole messages, some continuations, aborts and noise
        produced   = 0;
        first_kind = 1'b1;
        while (produced < RANDOM_WORDS) begin
            kind       = first_kind ? 0 : $urandom_range(0, 9);
            first_kind = 1'b0;
            if (kind <= 6) begin
                n = 16 * $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_word(pick_word(), i == 0);
            end else if (kind == 7) begin
                n = 16;
                for (int i = 0; i < n; i++)
                    push_word(pick_word(), 1'b0);
            end else if (kind == 8) begin
                n = $urandom_range(1, 15);
                for (int i = 0; i < n; i++)
                    push_word(pick_word(), i == 0);
            end else begin
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++)
                    push_word(pick_word(), ($urandom_range(0, 3) == 0));
            end
            produced += n;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (word_queue.size() != 0)
            @(posedge i_clk);
        while (expected_digests.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/sm3bc_pkg.sv
src/sm3bc_ctrl.sv
src/sm3bc_datapath.sv
src/sm3_block_compression.sv
src/sm3bc_checker.sv
bench/tb_top.sv
